[hw/rtl/tsbb_pkg.sv]
// Package with the word types, limits and saturation helper for the bounding box block.
package tsbb_pkg;

  // Limits of the signed 32-bit coordinate range.
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Shape codes carried in the op field.
  localparam logic OP_CIRCLE = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // Number of fraction bits of the Q2.14 trig values.
  localparam int unsigned TRIG_FRAC = 14;

  // One input word: a local point, the body transform and the shape code.
  typedef struct packed {
    logic               op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [30:0] radius;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last;
  } in_word_t;

  // One output word: the axis-aligned box.
  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } out_word_t;

  // Clamp a 35-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 35'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/transformed_shape_bounding_box.sv]
// Bounding box of a rigidly placed circle or convex polygon, as a five-register pipeline.
//
// Each word carries a local point and the body transform (cosine, sine, position). The block
// takes one word per clock cycle unless the output side stalls. Stages: input register, four
// floored 32x16 products, rotated point, translated point, and the result register, where
// polygon vertices fold into running min/max bounds. A circle word gives its box at once (center
// plus and minus radius) and leaves the polygon bounds alone; a vertex marked last gives the
// polygon box and resets the bounds. The bounds fold needs only a single compare per axis
// against the stored bounds. A stall on the output side holds the whole pipeline; input stall
// is high only while a box waits to be taken.
module transformed_shape_bounding_box
  import tsbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  // Product stage contents.
  typedef struct packed {
    logic               op;
    logic               last;
    logic        [30:0] radius;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [33:0] xc;
    logic signed [33:0] ys;
    logic signed [33:0] xs;
    logic signed [33:0] yc;
  } prod_t;

  // Rotated and translated point stage contents.
  typedef struct packed {
    logic               op;
    logic               last;
    logic        [30:0] radius;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } point_t;

  logic      advance;
  in_word_t  s1_q;
  logic      s1_valid_q;
  prod_t     s2_d, s2_q;
  logic      s2_valid_q;
  point_t    s3_d, s3_q;
  logic      s3_valid_q;
  point_t    s4_d, s4_q;
  logic      s4_valid_q;
  out_word_t out_d, out_q;
  logic      out_valid_d, out_valid_q;

  logic signed [47:0] prod_xc, prod_ys, prod_xs, prod_yc;
  logic signed [34:0] rot_x, rot_y, wld_x, wld_y;
  logic signed [34:0] rad_ext;

  logic signed [31:0] run_min_x_q, run_min_y_q, run_max_x_q, run_max_y_q;
  logic signed [31:0] run_min_x_d, run_min_y_d, run_max_x_d, run_max_y_d;
  logic signed [31:0] fold_min_x, fold_min_y, fold_max_x, fold_max_y;

  // The pipeline moves as a whole whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // Products of the point and the trig values, floored to Q16.16.
  assign prod_xc = s1_q.point_x * s1_q.cos_angle;
  assign prod_ys = s1_q.point_y * s1_q.sin_angle;
  assign prod_xs = s1_q.point_x * s1_q.sin_angle;
  assign prod_yc = s1_q.point_y * s1_q.cos_angle;

  always_comb begin
    s2_d        = '0;
    s2_d.op     = s1_q.op;
    s2_d.last   = s1_q.last;
    s2_d.radius = s1_q.radius;
    s2_d.pos_x  = s1_q.pos_x;
    s2_d.pos_y  = s1_q.pos_y;
    s2_d.xc     = prod_xc[47:TRIG_FRAC];
    s2_d.ys     = prod_ys[47:TRIG_FRAC];
    s2_d.xs     = prod_xs[47:TRIG_FRAC];
    s2_d.yc     = prod_yc[47:TRIG_FRAC];
  end

  // Rotation: combine the floored products with saturation.
  assign rot_x = 35'(s2_q.xc) - 35'(s2_q.ys);
  assign rot_y = 35'(s2_q.xs) + 35'(s2_q.yc);

  always_comb begin
    s3_d        = '0;
    s3_d.op     = s2_q.op;
    s3_d.last   = s2_q.last;
    s3_d.radius = s2_q.radius;
    s3_d.pos_x  = s2_q.pos_x;
    s3_d.pos_y  = s2_q.pos_y;
    s3_d.px     = sat32(rot_x);
    s3_d.py     = sat32(rot_y);
  end

  // Translation by the body position with saturation.
  assign wld_x = 35'(s3_q.px) + 35'(s3_q.pos_x);
  assign wld_y = 35'(s3_q.py) + 35'(s3_q.pos_y);

  always_comb begin
    s4_d    = s3_q;
    s4_d.px = sat32(wld_x);
    s4_d.py = sat32(wld_y);
  end

  // Fold the vertex into the running bounds.
  assign fold_min_x = (s4_q.px < run_min_x_q) ? s4_q.px : run_min_x_q;
  assign fold_min_y = (s4_q.py < run_min_y_q) ? s4_q.py : run_min_y_q;
  assign fold_max_x = (s4_q.px > run_max_x_q) ? s4_q.px : run_max_x_q;
  assign fold_max_y = (s4_q.py > run_max_y_q) ? s4_q.py : run_max_y_q;

  assign rad_ext = 35'(signed'({1'b0, s4_q.radius}));

  // Result selection: circle box, polygon box on the last vertex, or nothing.
  always_comb begin
    run_min_x_d = run_min_x_q;
    run_min_y_d = run_min_y_q;
    run_max_x_d = run_max_x_q;
    run_max_y_d = run_max_y_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    if (s4_valid_q) begin
      if (s4_q.op == OP_CIRCLE) begin
        out_valid_d     = 1'b1;
        out_d.box_min_x = sat32(35'(s4_q.px) - rad_ext);
        out_d.box_min_y = sat32(35'(s4_q.py) - rad_ext);
        out_d.box_max_x = sat32(35'(s4_q.px) + rad_ext);
        out_d.box_max_y = sat32(35'(s4_q.py) + rad_ext);
      end else if (s4_q.last) begin
        out_valid_d     = 1'b1;
        out_d.box_min_x = fold_min_x;
        out_d.box_min_y = fold_min_y;
        out_d.box_max_x = fold_max_x;
        out_d.box_max_y = fold_max_y;
        run_min_x_d     = S32_MAX;
        run_min_y_d     = S32_MAX;
        run_max_x_d     = S32_MIN;
        run_max_y_d     = S32_MIN;
      end else begin
        run_min_x_d = fold_min_x;
        run_min_y_d = fold_min_y;
        run_max_x_d = fold_max_x;
        run_max_y_d = fold_max_y;
      end
    end
  end

  // Valid bits and running bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_min_x_q <= S32_MAX;
      run_min_y_q <= S32_MAX;
      run_max_x_q <= S32_MIN;
      run_max_y_q <= S32_MIN;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= out_valid_d;
      run_min_x_q <= run_min_x_d;
      run_min_y_q <= run_min_y_d;
      run_max_x_q <= run_max_x_d;
      run_max_y_q <= run_max_y_d;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q  <= in_data_i;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input side is held only while a finished box waits.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  // Every box given out is ordered on both axes.
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.box_min_x <= out_data_o.box_max_x) &&
                    (out_data_o.box_min_y <= out_data_o.box_max_y))
    else $error("box minimum exceeds maximum");

  // The last vertex of a polygon returns the bounds to their empty values.
  a_bounds_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s4_valid_q && (s4_q.op == OP_VERTEX) && s4_q.last |=>
      (run_min_x_q == S32_MAX) && (run_min_y_q == S32_MAX) &&
      (run_max_x_q == S32_MIN) && (run_max_y_q == S32_MIN))
    else $error("bounds not cleared after last vertex");

  // A new result only appears from a word that left the translation stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s4_valid_q))
    else $error("result without a source word");

endmodule

[verif/tb_transformed_shape_bounding_box.sv]
// Self-checking testbench for the transformed shape bounding box block.
`timescale 1ns / 100ps

module tb_transformed_shape_bounding_box;
  import tsbb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // Predicts the box of each word and keeps the boxes still to come.
  class box_scoreboard;
    logic signed [31:0] lo_x, lo_y, hi_x, hi_y;
    out_word_t          boxes_due[$];
    int unsigned        mismatches;

    function new();
      clear_bounds();
      mismatches = 0;
    endfunction

    function void clear_bounds();
      lo_x = S32_MAX;
      lo_y = S32_MAX;
      hi_x = S32_MIN;
      hi_y = S32_MIN;
    endfunction

    // Q16.16 times Q2.14, floored back to Q16.16.
    function longint floor_q14(logic signed [31:0] a, logic signed [15:0] t);
      longint p;
      p = longint'(a) * longint'(t);
      return p >>> TRIG_FRAC;
    endfunction

    function logic signed [31:0] clamp_s32(longint v);
      logic signed [31:0] r;
      if (v > longint'(S32_MAX)) begin
        r = S32_MAX;
      end else if (v < longint'(S32_MIN)) begin
        r = S32_MIN;
      end else begin
        r = 32'(v);
      end
      return r;
    endfunction

    // Rotate, translate and fold one accepted word.
    function void note_word(in_word_t w);
      logic signed [31:0] rx, ry, wx, wy;
      longint             rad;
      out_word_t          box;
      rx = clamp_s32(floor_q14(w.point_x, w.cos_angle) - floor_q14(w.point_y, w.sin_angle));
      ry = clamp_s32(floor_q14(w.point_x, w.sin_angle) + floor_q14(w.point_y, w.cos_angle));
      wx = clamp_s32(longint'(rx) + longint'(w.pos_x));
      wy = clamp_s32(longint'(ry) + longint'(w.pos_y));
      rad = longint'(w.radius);
      if (w.op == OP_CIRCLE) begin
        box.box_min_x = clamp_s32(longint'(wx) - rad);
        box.box_min_y = clamp_s32(longint'(wy) - rad);
        box.box_max_x = clamp_s32(longint'(wx) + rad);
        box.box_max_y = clamp_s32(longint'(wy) + rad);
        boxes_due.push_back(box);
        return;
      end
      if (wx < lo_x) lo_x = wx;
      if (wx > hi_x) hi_x = wx;
      if (wy < lo_y) lo_y = wy;
      if (wy > hi_y) hi_y = wy;
      if (w.last) begin
        box.box_min_x = lo_x;
        box.box_min_y = lo_y;
        box.box_max_x = hi_x;
        box.box_max_y = hi_y;
        boxes_due.push_back(box);
        clear_bounds();
      end
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare a box leaving the block with the oldest prediction.
    task check_box(out_word_t got);
      out_word_t want;
      if (boxes_due.size() == 0) begin
        report($sformatf("box %h arrived with none predicted", got));
        return;
      end
      want = boxes_due.pop_front();
      if (got.box_min_x !== want.box_min_x)
        report($sformatf("box_min_x got %h, predicted %h", got.box_min_x, want.box_min_x));
      if (got.box_min_y !== want.box_min_y)
        report($sformatf("box_min_y got %h, predicted %h", got.box_min_y, want.box_min_y));
      if (got.box_max_x !== want.box_max_x)
        report($sformatf("box_max_x got %h, predicted %h", got.box_max_x, want.box_max_x));
      if (got.box_max_y !== want.box_max_y)
        report($sformatf("box_max_y got %h, predicted %h", got.box_max_y, want.box_max_y));
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_word_t out_data_o;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles = 0;
  box_scoreboard sb = new();

  transformed_shape_bounding_box u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // Free-running clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Random back-pressure on the result side.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Note accepted words, then check accepted boxes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_word(in_data);
      if (out_valid_o && !out_stall) sb.check_box(out_data_o);
    end
  end

  // Watchdog on cycles with no word moving in either direction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("transformed_shape_bounding_box test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_word_t make_word(logic op, logic signed [31:0] px,
                                         logic signed [31:0] py, logic [30:0] rad,
                                         logic signed [15:0] c, logic signed [15:0] s,
                                         logic signed [31:0] tx, logic signed [31:0] ty,
                                         logic lst);
    in_word_t w;
    w.op        = op;
    w.point_x   = px;
    w.point_y   = py;
    w.radius    = rad;
    w.cos_angle = c;
    w.sin_angle = s;
    w.pos_x     = tx;
    w.pos_y     = ty;
    w.last      = lst;
    return w;
  endfunction

  // Coordinates: mostly moderate, some full range, some at the ends.
  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = S32_MAX;
          1: v = S32_MIN;
          2: v = '0;
          3: v = -32'sd1;
          default: v = ONE_Q16;
        endcase
      end
      1, 2: v = $urandom();
      default: v = 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
    return v;
  endfunction

  // Trig values: mostly in range, some at the ends, some any 16-bit value.
  function automatic logic signed [15:0] rand_trig();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      7: begin
        case ($urandom_range(0, 2))
          0: v = ONE_Q14;
          1: v = -ONE_Q14;
          default: v = '0;
        endcase
      end
      8, 9: v = 16'($urandom());
      default: v = 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_radius();
    logic [30:0] v;
    case ($urandom_range(0, 9))
      6, 7, 8: v = 31'($urandom());
      9: v = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
      default: v = 31'($urandom_range(0, 1 << 22));
    endcase
    return v;
  endfunction

  // Offer one word after a random idle gap and hold it until accepted.
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_circle(logic signed [31:0] px, logic signed [31:0] py,
                             logic [30:0] rad, logic signed [15:0] c, logic signed [15:0] s,
                             logic signed [31:0] tx, logic signed [31:0] ty, logic lst);
    send_word(make_word(OP_CIRCLE, px, py, rad, c, s, tx, ty, lst));
  endtask

  task automatic send_vertex(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [15:0] c, logic signed [15:0] s,
                             logic signed [31:0] tx, logic signed [31:0] ty, logic lst);
    send_word(make_word(OP_VERTEX, px, py, rand_radius(), c, s, tx, ty, lst));
  endtask

  // Field extremes, flooring, saturation and the circle and polygon cases.
  task automatic run_directed();
    // Circles: identity, last flag ignored, saturation at both ends, out-of-range trig.
    send_circle('0, '0, '0, ONE_Q14, '0, '0, '0, 1'b0);
    send_circle(ONE_Q16, 2 * ONE_Q16, 31'(ONE_Q16), ONE_Q14, '0, 5 * ONE_Q16, -3 * ONE_Q16,
                1'b1);
    send_circle(S32_MAX, S32_MAX, 31'h7FFF_FFFF, ONE_Q14, '0, S32_MAX, S32_MAX, 1'b0);
    send_circle(S32_MIN, S32_MIN, 31'h7FFF_FFFF, ONE_Q14, -ONE_Q14, S32_MIN, S32_MIN, 1'b0);
    send_circle(S32_MIN, '0, '0, -ONE_Q14, '0, '0, '0, 1'b0);
    send_circle(-32'sd1, 32'sd3, 31'd1, 16'sh8000, 16'sh7FFF, '0, '0, 1'b0);
    send_circle(-32'sd1, -32'sd1, '0, 16'sd1, 16'sd1, '0, '0, 1'b0);
    // Square turned a quarter turn, with a circle in the middle that must not disturb it.
    send_vertex(ONE_Q16, ONE_Q16, '0, ONE_Q14, 10 * ONE_Q16, 20 * ONE_Q16, 1'b0);
    send_vertex(-ONE_Q16, ONE_Q16, '0, ONE_Q14, 10 * ONE_Q16, 20 * ONE_Q16, 1'b0);
    send_circle(7 * ONE_Q16, '0, 31'(ONE_Q16), ONE_Q14, '0, '0, '0, 1'b1);
    send_vertex(-ONE_Q16, -ONE_Q16, '0, ONE_Q14, 10 * ONE_Q16, 20 * ONE_Q16, 1'b0);
    send_vertex(ONE_Q16, -ONE_Q16, '0, ONE_Q14, 10 * ONE_Q16, 20 * ONE_Q16, 1'b1);
    // Single vertex polygon at the field extremes.
    send_vertex(S32_MAX, S32_MIN, 16'sh7FFF, 16'sh8000, S32_MIN, S32_MAX, 1'b1);
    // Two vertices that saturate to opposite ends.
    send_vertex(ONE_Q16, ONE_Q16, ONE_Q14, '0, S32_MAX, S32_MIN, 1'b0);
    send_vertex(-ONE_Q16, -ONE_Q16, ONE_Q14, '0, S32_MIN, S32_MAX, 1'b1);
    // Zero trig puts every vertex on the position.
    send_vertex(S32_MAX, S32_MAX, '0, '0, -5 * ONE_Q16, 3 * ONE_Q16, 1'b0);
    send_vertex(-32'sd12345, 32'sd999, '0, '0, -5 * ONE_Q16, 3 * ONE_Q16, 1'b1);
  endtask

  // Random circles and polygons over four idling phases.
  task automatic run_random();
    int unsigned        sent, nv;
    logic signed [15:0] c, s;
    logic signed [31:0] tx, ty;
    bit                 mixed;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent * 4) / RANDOM_ITEMS)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 56;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct <= 37;
        end
      endcase
      if ($urandom_range(0, 99) < 35) begin
        send_circle(rand_coord(), rand_coord(), rand_radius(), rand_trig(), rand_trig(),
                    rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        c  = rand_trig();
        s  = rand_trig();
        tx = rand_coord();
        ty = rand_coord();
        // A few polygons change the transform from vertex to vertex.
        mixed = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < nv; k++) begin
          if (mixed) begin
            c  = rand_trig();
            s  = rand_trig();
            tx = rand_coord();
            ty = rand_coord();
          end
          if ($urandom_range(0, 19) == 0) begin
            send_circle(rand_coord(), rand_coord(), rand_radius(), rand_trig(), rand_trig(),
                        rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
            sent++;
          end
          send_vertex(rand_coord(), rand_coord(), c, s, tx, ty, k == nv - 1);
          sent++;
        end
      end
    end
  endtask

  // Reset, stimulus, drain and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.boxes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.boxes_due.size() == 0) begin
      $display("transformed_shape_bounding_box test passed");
    end else begin
      $display("transformed_shape_bounding_box test failed");
    end
    $finish;
  end

endmodule
